// ----- rtl/core/lbr_pkg.sv -----
// ---------------------------------------------------------------------------
// lbr_pkg
// shared constants, codes and types of the log-block ack/nack receiver
// ---------------------------------------------------------------------------
package lbr_pkg;

    // block map geometry
    localparam int MAP_DEPTH   = 1024;
    localparam int MASK_WIDTH  = 32;
    localparam int BLOCK_BYTES = 200;
    localparam int STOP_REPEAT = 3;

    localparam int MAP_IDX_W = $clog2(MAP_DEPTH);
    localparam int BIT_W     = $clog2(MASK_WIDTH);
    localparam int ROWS      = (MAP_DEPTH + MASK_WIDTH - 1) / MASK_WIDTH;
    localparam int ROW_W     = (ROWS > 1) ? $clog2(ROWS) : 1;

    // port field widths
    localparam int BLK_W   = 32;
    localparam int OFF_W   = 40;
    localparam int MMASK_W = 32;

    // result script: longest fixed sequence is the stop burst plus close
    localparam int SCR_DEPTH = STOP_REPEAT + 1;
    localparam int SCR_IW    = $clog2(SCR_DEPTH);
    localparam int SCR_LW    = $clog2(SCR_DEPTH + 1);

    typedef enum logic [2:0] {
        REQ_DATA    = 3'd0,
        REQ_NACK    = 3'd1,
        REQ_POLL    = 3'd2,
        REQ_START   = 3'd3,
        REQ_STOP    = 3'd4,
        REQ_CONNECT = 3'd5
    } req_t;

    typedef enum logic [2:0] {
        ACT_ACK    = 3'd0,
        ACT_NACK   = 3'd1,
        ACT_STOP   = 3'd2,
        ACT_START  = 3'd3,
        ACT_OPEN   = 3'd4,
        ACT_CLOSE  = 3'd5,
        ACT_WRITE  = 3'd6,
        ACT_STATUS = 3'd7
    } action_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DATA_WR,
        ST_SCRIPT,
        ST_NACK,
        ST_NACK_END
    } state_t;

    typedef enum logic {
        BOP_SET,
        BOP_MISS
    } bit_op_t;

    typedef struct packed {
        logic                  rd;
        logic                  wr;
        logic                  clr;
        logic [ROW_W-1:0]      rd_row;
        logic [ROW_W-1:0]      wr_row;
        logic [MASK_WIDTH-1:0] wdata;
    } map_req_t;

endpackage

// ----- rtl/core/lbr_map_mem.sv -----
// ---------------------------------------------------------------------------
// lbr_map_mem
// received-block bitmap, one row per mask window, with row valid bits
// ---------------------------------------------------------------------------
module lbr_map_mem
    import lbr_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  map_req_t              req,
    output logic [MASK_WIDTH-1:0] rdata
);

    logic [MASK_WIDTH-1:0] mem [ROWS];
    logic [ROWS-1:0]       row_vld_reg;
    logic [MASK_WIDTH-1:0] rdata_reg;
    logic                  rvld_reg;

    // row storage, no reset
    always_ff @(posedge aclk) begin
        if (req.wr) begin
            mem[req.wr_row] <= req.wdata;
        end
        if (req.rd) begin
            rdata_reg <= mem[req.rd_row];
        end
    end

    // an invalid row reads as all clear
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_vld_reg <= '0;
            rvld_reg    <= 1'b0;
        end else begin
            if (req.clr) begin
                row_vld_reg <= '0;
            end else if (req.wr) begin
                row_vld_reg[req.wr_row] <= 1'b1;
            end
            if (req.rd) begin
                rvld_reg <= row_vld_reg[req.rd_row];
            end
        end
    end

    assign rdata = rvld_reg ? rdata_reg : '0;

endmodule

// ----- rtl/core/lbr_bit_unit.sv -----
// ---------------------------------------------------------------------------
// lbr_bit_unit
// shared row unit: sets a received bit or forms a window's missing mask
// ---------------------------------------------------------------------------
module lbr_bit_unit
    import lbr_pkg::*;
(
    input  bit_op_t               op,
    input  logic [MASK_WIDTH-1:0] row_data,
    input  logic [ROW_W-1:0]      row_idx,
    input  logic [BIT_W-1:0]      bit_idx,
    input  logic [MAP_IDX_W-1:0]  highest,
    output logic [MASK_WIDTH-1:0] result
);

    logic [ROW_W-1:0]      h_row;
    logic [BIT_W-1:0]      h_bit;
    logic [MASK_WIDTH-1:0] limit;

    assign h_row = highest[MAP_IDX_W-1:BIT_W];
    assign h_bit = highest[BIT_W-1:0];

    // only blocks below the highest recorded one count as missing
    always_comb begin
        if (row_idx < h_row) begin
            limit = '1;
        end else if (row_idx == h_row) begin
            limit = (MASK_WIDTH'(1) << h_bit) - MASK_WIDTH'(1);
        end else begin
            limit = '0;
        end
    end

    always_comb begin
        case (op)
            BOP_SET: begin
                result = row_data | (MASK_WIDTH'(1) << bit_idx);
            end
            BOP_MISS: begin
                result = ~row_data & limit;
            end
            default: begin
                result = '0;
            end
        endcase
    end

endmodule

// ----- rtl/core/log_block_ack_nack_receiver_core.sv -----
// ---------------------------------------------------------------------------
// log_block_ack_nack_receiver_core
// receiver side of a streamed log-block transfer (selective-repeat style)
// ---------------------------------------------------------------------------
// One request is taken at a time; s_tready is high only while the sequencer
// is idle, and results leave through a one-entry output register, so a new
// request can be taken while the last result still waits on m_tready.
// A data block is accepted, updates its bitmap row in ST_DATA_WR (tracked
// blocks only) and then emits its results (up to three) from the script.
// Start, stop and arm-poll requests emit one result per cycle, while the
// output is free, from a short action script (up to four results). A
// nack tick walks the bitmap one 32-block window per cycle, unless a found
// mask waits on the output, from block zero up to the highest recorded
// block, then flushes the final mask. Connect events and ignored requests
// finish in the accept cycle; a stall on m_tready simply holds the sequencer.
// The bitmap is a 32-row memory read and written one row at a time through
// a shared set/mask unit; per-row valid bits clear it at once on reset and
// on log close, so no clearing pass is needed.
// ---------------------------------------------------------------------------
module log_block_ack_nack_receiver_core
    import lbr_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    // request stream
    input  logic         s_tvalid,
    output logic         s_tready,
    // tdata, low bit up: block_number[31:0], armed_now, link_up,
    // partner_capable, zero fill
    input  logic [39:0]  s_tdata,
    // tuser: req_type[2:0]
    input  logic [2:0]   s_tuser,
    // result stream
    output logic         m_tvalid,
    input  logic         m_tready,
    // tdata, low bit up: block_number_out[31:0], write_offset[39:0],
    // missing_mask[31:0], success, untracked, zero fill
    output logic [111:0] m_tdata,
    // tuser: action[2:0]
    output logic [2:0]   m_tuser,
    output logic         m_tlast,
    // configuration: start_on_connect
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic         cfg_data
);

    // input fields
    logic [BLK_W-1:0] in_blk;
    logic             in_armed;
    logic             in_link;
    logic             in_capable;
    req_t             in_req;

    assign in_blk     = s_tdata[BLK_W-1:0];
    assign in_armed   = s_tdata[BLK_W];
    assign in_link    = s_tdata[BLK_W+1];
    assign in_capable = s_tdata[BLK_W+2];
    assign in_req     = req_t'(s_tuser);

    // sequencer and protocol state
    state_t                state_reg, state_next;
    logic                  stopped_reg, stopped_next;
    logic                  armed_reg, armed_next;
    logic                  open_reg, open_next;
    logic                  any_reg, any_next;
    logic [MAP_IDX_W-1:0]  highest_reg, highest_next;
    logic                  soc_reg, soc_next;
    logic [SCR_IW-1:0]     scr_idx_reg, scr_idx_next;
    logic [SCR_LW-1:0]     scr_len_reg, scr_len_next;
    logic [ROW_W-1:0]      row_reg, row_next;
    logic                  pend_valid_reg, pend_valid_next;
    logic                  m_tvalid_reg, m_tvalid_next;

    // item payload
    action_t               act_q_reg [SCR_DEPTH];
    action_t               act_q_next [SCR_DEPTH];
    logic [BLK_W-1:0]      blk_reg, blk_next;
    logic [OFF_W-1:0]      offset_reg, offset_next;
    logic                  untr_reg, untr_next;
    logic [ROW_W-1:0]      pend_row_reg, pend_row_next;
    logic [MASK_WIDTH-1:0] pend_mask_reg, pend_mask_next;

    // output register
    action_t               out_act_reg, out_act_next;
    logic [BLK_W-1:0]      out_blk_reg, out_blk_next;
    logic [OFF_W-1:0]      out_off_reg, out_off_next;
    logic [MMASK_W-1:0]    out_mask_reg, out_mask_next;
    logic                  out_ok_reg, out_ok_next;
    logic                  out_untr_reg, out_untr_next;
    logic                  out_last_reg, out_last_next;

    // shared units
    map_req_t              map_req;
    logic [MASK_WIDTH-1:0] map_rdata;
    bit_op_t               bu_op;
    logic [ROW_W-1:0]      bu_row;
    logic [MASK_WIDTH-1:0] bu_result;

    logic                  in_acc;
    logic                  out_free;
    logic                  out_load;
    logic                  in_untr;
    logic                  more_rows;
    logic                  nack_go;
    action_t               scr_act;
    logic                  scr_last;

    lbr_map_mem u_map (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (map_req),
        .rdata   (map_rdata)
    );

    lbr_bit_unit u_bit (
        .op       (bu_op),
        .row_data (map_rdata),
        .row_idx  (bu_row),
        .bit_idx  (blk_reg[BIT_W-1:0]),
        .highest  (highest_reg),
        .result   (bu_result)
    );

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign in_acc    = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign in_untr   = |in_blk[BLK_W-1:MAP_IDX_W];

    // current script entry
    assign scr_act  = act_q_reg[scr_idx_reg];
    assign scr_last = ((SCR_LW'(scr_idx_reg) + SCR_LW'(1)) == scr_len_reg);

    // window after the current one still starts below the highest block
    assign more_rows = ({1'b0, row_reg + ROW_W'(1), {BIT_W{1'b0}}} <
                        (ROW_W+BIT_W+1)'(highest_reg)) &&
                       (row_reg != ROW_W'(ROWS - 1));

    // a found mask must first push the held one out
    assign nack_go = !((bu_result != '0) && pend_valid_reg && !out_free);

    assign bu_op  = (state_reg == ST_DATA_WR) ? BOP_SET : BOP_MISS;
    assign bu_row = (state_reg == ST_DATA_WR) ? blk_reg[MAP_IDX_W-1:BIT_W] : row_reg;

    always_comb begin
        state_next      = state_reg;
        stopped_next    = stopped_reg;
        armed_next      = armed_reg;
        open_next       = open_reg;
        any_next        = any_reg;
        highest_next    = highest_reg;
        soc_next        = soc_reg;
        scr_idx_next    = scr_idx_reg;
        scr_len_next    = scr_len_reg;
        row_next        = row_reg;
        pend_valid_next = pend_valid_reg;
        act_q_next      = act_q_reg;
        blk_next        = blk_reg;
        offset_next     = offset_reg;
        untr_next       = untr_reg;
        pend_row_next   = pend_row_reg;
        pend_mask_next  = pend_mask_reg;
        out_act_next    = out_act_reg;
        out_blk_next    = out_blk_reg;
        out_off_next    = out_off_reg;
        out_mask_next   = out_mask_reg;
        out_ok_next     = out_ok_reg;
        out_untr_next   = out_untr_reg;
        out_last_next   = out_last_reg;
        out_load        = 1'b0;
        map_req         = '0;

        if (cfg_valid) begin
            soc_next = cfg_data;
        end

        case (state_reg)
            ST_IDLE: begin
                if (in_acc) begin
                    blk_next     = in_blk;
                    offset_next  = {{(OFF_W-BLK_W){1'b0}}, in_blk} * OFF_W'(BLOCK_BYTES);
                    untr_next    = in_untr;
                    scr_idx_next = '0;
                    case (in_req)
                        REQ_DATA: begin
                            if (stopped_reg) begin
                                act_q_next[0] = ACT_STOP;
                                scr_len_next  = SCR_LW'(1);
                                state_next    = ST_SCRIPT;
                            end else if (open_reg || (in_blk == '0)) begin
                                open_next = 1'b1;
                                if (!open_reg) begin
                                    act_q_next[0] = ACT_OPEN;
                                    act_q_next[1] = ACT_WRITE;
                                    act_q_next[2] = ACT_ACK;
                                    scr_len_next  = SCR_LW'(3);
                                end else begin
                                    act_q_next[0] = ACT_WRITE;
                                    act_q_next[1] = ACT_ACK;
                                    scr_len_next  = SCR_LW'(2);
                                end
                                if (!in_untr) begin
                                    map_req.rd     = 1'b1;
                                    map_req.rd_row = in_blk[MAP_IDX_W-1:BIT_W];
                                    state_next     = ST_DATA_WR;
                                end else begin
                                    state_next = ST_SCRIPT;
                                end
                            end
                        end
                        REQ_NACK: begin
                            if (!stopped_reg && any_reg && (highest_reg != '0)) begin
                                row_next       = '0;
                                map_req.rd     = 1'b1;
                                map_req.rd_row = '0;
                                state_next     = ST_NACK;
                            end
                        end
                        REQ_POLL: begin
                            if (!stopped_reg && (in_armed != armed_reg)) begin
                                armed_next = in_armed;
                                state_next = ST_SCRIPT;
                                if (!in_armed) begin
                                    for (int k = 0; k < STOP_REPEAT; k++) begin
                                        act_q_next[k] = ACT_STOP;
                                    end
                                    act_q_next[STOP_REPEAT] = ACT_CLOSE;
                                    scr_len_next = SCR_LW'(STOP_REPEAT + 1);
                                    open_next    = 1'b0;
                                    map_req.clr  = 1'b1;
                                    any_next     = 1'b0;
                                    highest_next = '0;
                                end else begin
                                    act_q_next[0] = ACT_OPEN;
                                    act_q_next[1] = ACT_START;
                                    scr_len_next  = SCR_LW'(2);
                                    open_next     = 1'b1;
                                end
                            end
                        end
                        REQ_START: begin
                            act_q_next[0] = ACT_START;
                            act_q_next[1] = ACT_OPEN;
                            act_q_next[2] = ACT_STATUS;
                            scr_len_next  = SCR_LW'(3);
                            open_next     = 1'b1;
                            stopped_next  = 1'b0;
                            state_next    = ST_SCRIPT;
                        end
                        REQ_STOP: begin
                            act_q_next[0] = ACT_STOP;
                            act_q_next[1] = ACT_CLOSE;
                            act_q_next[2] = ACT_STATUS;
                            scr_len_next  = SCR_LW'(3);
                            open_next     = 1'b0;
                            map_req.clr   = 1'b1;
                            any_next      = 1'b0;
                            highest_next  = '0;
                            stopped_next  = 1'b1;
                            state_next    = ST_SCRIPT;
                        end
                        REQ_CONNECT: begin
                            if (in_link && soc_reg && in_capable) begin
                                armed_next   = in_armed;
                                stopped_next = 1'b0;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end

            // read-modify-write of the block's bitmap row
            ST_DATA_WR: begin
                map_req.wr     = 1'b1;
                map_req.wr_row = blk_reg[MAP_IDX_W-1:BIT_W];
                map_req.wdata  = bu_result;
                if (!any_reg || (blk_reg[MAP_IDX_W-1:0] > highest_reg)) begin
                    highest_next = blk_reg[MAP_IDX_W-1:0];
                end
                any_next   = 1'b1;
                state_next = ST_SCRIPT;
            end

            // one scripted result per transfer slot
            ST_SCRIPT: begin
                if (out_free) begin
                    out_load      = 1'b1;
                    out_act_next  = scr_act;
                    out_blk_next  = ((scr_act == ACT_WRITE) || (scr_act == ACT_ACK)) ?
                                    blk_reg : '0;
                    out_off_next  = (scr_act == ACT_WRITE) ? offset_reg : '0;
                    out_mask_next = '0;
                    out_ok_next   = (scr_act == ACT_STATUS);
                    out_untr_next = ((scr_act == ACT_WRITE) || (scr_act == ACT_ACK)) &&
                                    untr_reg;
                    out_last_next = scr_last;
                    scr_idx_next  = scr_idx_reg + SCR_IW'(1);
                    if (scr_last) begin
                        state_next = ST_IDLE;
                    end
                end
            end

            // window sweep, one row per cycle unless a found mask waits on the output;
            // one mask is held back so the final one can carry tlast
            ST_NACK: begin
                if (nack_go) begin
                    if (bu_result != '0) begin
                        if (pend_valid_reg) begin
                            out_load      = 1'b1;
                            out_act_next  = ACT_NACK;
                            out_blk_next  = BLK_W'({pend_row_reg, {BIT_W{1'b0}}});
                            out_off_next  = '0;
                            out_mask_next = MMASK_W'(pend_mask_reg);
                            out_ok_next   = 1'b0;
                            out_untr_next = 1'b0;
                            out_last_next = 1'b0;
                        end
                        pend_valid_next = 1'b1;
                        pend_row_next   = row_reg;
                        pend_mask_next  = bu_result;
                    end
                    if (more_rows) begin
                        row_next       = row_reg + ROW_W'(1);
                        map_req.rd     = 1'b1;
                        map_req.rd_row = row_reg + ROW_W'(1);
                    end else begin
                        state_next = ST_NACK_END;
                    end
                end
            end

            ST_NACK_END: begin
                if (!pend_valid_reg) begin
                    state_next = ST_IDLE;
                end else if (out_free) begin
                    out_load        = 1'b1;
                    out_act_next    = ACT_NACK;
                    out_blk_next    = BLK_W'({pend_row_reg, {BIT_W{1'b0}}});
                    out_off_next    = '0;
                    out_mask_next   = MMASK_W'(pend_mask_reg);
                    out_ok_next     = 1'b0;
                    out_untr_next   = 1'b0;
                    out_last_next   = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // output valid: set on load, dropped once the transfer completes
        if (out_load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            stopped_reg    <= 1'b1;
            armed_reg      <= 1'b0;
            open_reg       <= 1'b0;
            any_reg        <= 1'b0;
            highest_reg    <= '0;
            soc_reg        <= 1'b1;
            scr_idx_reg    <= '0;
            scr_len_reg    <= '0;
            row_reg        <= '0;
            pend_valid_reg <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            stopped_reg    <= stopped_next;
            armed_reg      <= armed_next;
            open_reg       <= open_next;
            any_reg        <= any_next;
            highest_reg    <= highest_next;
            soc_reg        <= soc_next;
            scr_idx_reg    <= scr_idx_next;
            scr_len_reg    <= scr_len_next;
            row_reg        <= row_next;
            pend_valid_reg <= pend_valid_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge aclk) begin
        act_q_reg     <= act_q_next;
        blk_reg       <= blk_next;
        offset_reg    <= offset_next;
        untr_reg      <= untr_next;
        pend_row_reg  <= pend_row_next;
        pend_mask_reg <= pend_mask_next;
        out_act_reg   <= out_act_next;
        out_blk_reg   <= out_blk_next;
        out_off_reg   <= out_off_next;
        out_mask_reg  <= out_mask_next;
        out_ok_reg    <= out_ok_next;
        out_untr_reg  <= out_untr_next;
        out_last_reg  <= out_last_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = out_act_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {6'b0, out_untr_reg, out_ok_reg, out_mask_reg, out_off_reg, out_blk_reg};

    // a waiting result is never overwritten
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> out_free)
        else $error("result loaded while previous transfer pending");

    // nack results only carry windows with a missing block
    a_nack_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && (out_act_reg == ACT_NACK)) |-> (out_mask_reg != '0))
        else $error("empty nack mask sent");

    // the held mask lives only inside a nack sweep
    a_pend_scope: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_valid_reg |-> ((state_reg == ST_NACK) || (state_reg == ST_NACK_END)))
        else $error("held nack mask outside sweep");

    // a nonzero highest block implies something was recorded
    a_highest_any: assert property (@(posedge aclk) disable iff (!aresetn)
        (highest_reg != '0) |-> any_reg)
        else $error("highest block set with empty map");

    // a stop request always leaves the receiver stopped with the log closed
    a_stop_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_acc && (in_req == REQ_STOP)) |=> (stopped_reg && !open_reg && !any_reg))
        else $error("stop request did not stop the receiver");

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// self-checking bench for the log-block ack/nack receiver core: a scoreboard
// class predicts every result from each accepted request and checks the
// result stream in order, while both stream sides idle and stall at random
// ---------------------------------------------------------------------------
module tb;
    import lbr_pkg::*;

    // request codes the block ignores
    localparam logic [2:0] REQ_SPARE_6 = 3'd6;
    localparam logic [2:0] REQ_SPARE_7 = 3'd7;

    localparam int MAX_WINDOWS  = 32;       // nack masks per tick
    localparam int SETTLE_TICKS = 48;       // covers a full nack sweep
    localparam int CYCLE_LIMIT  = 500000;
    localparam int PHASES       = 5;
    localparam int PHASE_ITEMS  = 37;       // with the directed run, about 210 items

    // one expected result transfer
    typedef struct {
        action_t     act;
        logic [31:0] blk;
        logic [39:0] off;
        logic [31:0] mask;
        logic        ok;
        logic        untr;
        logic        last;
    } log_result_t;

    // -----------------------------------------------------------------------
    // scoreboard: own copy of the receiver state, predicts results per
    // accepted request and checks the result stream against them
    // -----------------------------------------------------------------------
    class log_ack_scoreboard;
        log_result_t          pending_results[$];
        logic [MAP_DEPTH-1:0] block_seen;
        logic [9:0]           top_block;
        bit                   have_block;
        bit                   stopped;
        bit                   armed_state;
        bit                   log_open;
        bit                   start_on_connect;
        int                   mismatches;

        function new();
            block_seen       = '0;
            top_block        = '0;
            have_block       = 0;
            stopped          = 1;
            armed_state      = 0;
            log_open         = 0;
            start_on_connect = 1;
            mismatches       = 0;
        endfunction

        function void push(action_t act, logic [31:0] blk, logic [39:0] off,
                           logic [31:0] mask, logic ok, logic untr);
            log_result_t r;
            r.act  = act;
            r.blk  = blk;
            r.off  = off;
            r.mask = mask;
            r.ok   = ok;
            r.untr = untr;
            r.last = 1'b0;
            pending_results.push_back(r);
        endfunction

        function void close_log();
            log_open   = 0;
            block_seen = '0;
            top_block  = '0;
            have_block = 0;
            push(ACT_CLOSE, '0, '0, '0, 1'b0, 1'b0);
        endfunction

        // works out the results of one accepted request
        function void note_request(logic [2:0] req, logic [31:0] blk,
                                   bit armed, bit link, bit capable);
            int          queued_at_entry;
            int          windows;
            logic [63:0] product;
            logic [31:0] mask;
            bit          untr;
            log_result_t r;
            queued_at_entry = pending_results.size();
            windows         = 0;
            case (req)
                REQ_DATA: begin
                    if (stopped) begin
                        push(ACT_STOP, '0, '0, '0, 1'b0, 1'b0);
                    end else begin
                        // block zero opens a closed log
                        if (blk == 0 && !log_open) begin
                            log_open = 1;
                            push(ACT_OPEN, '0, '0, '0, 1'b0, 1'b0);
                        end
                        if (log_open) begin
                            product = {32'd0, blk} * 64'd200;
                            untr    = (blk >= MAP_DEPTH);
                            if (!untr) begin
                                block_seen[blk[9:0]] = 1'b1;
                                if (!have_block || blk[9:0] > top_block)
                                    top_block = blk[9:0];
                                have_block = 1;
                            end
                            push(ACT_WRITE, blk, product[39:0], '0, 1'b0, untr);
                            push(ACT_ACK, blk, '0, '0, 1'b0, untr);
                        end
                    end
                end
                REQ_NACK: begin
                    if (!stopped && have_block) begin
                        for (int base = 0; base < top_block && windows < MAX_WINDOWS;
                             base += MASK_WIDTH) begin
                            mask = '0;
                            for (int k = 0; k < MASK_WIDTH; k++) begin
                                if (base + k < top_block && !block_seen[base + k])
                                    mask[k] = 1'b1;
                            end
                            if (mask != 0) begin
                                push(ACT_NACK, base, '0, mask, 1'b0, 1'b0);
                                windows++;
                            end
                        end
                    end
                end
                REQ_POLL: begin
                    if (!stopped && armed != armed_state) begin
                        armed_state = armed;
                        if (!armed) begin
                            repeat (STOP_REPEAT) push(ACT_STOP, '0, '0, '0, 1'b0, 1'b0);
                            close_log();
                        end else begin
                            log_open = 1;
                            push(ACT_OPEN, '0, '0, '0, 1'b0, 1'b0);
                            push(ACT_START, '0, '0, '0, 1'b0, 1'b0);
                        end
                    end
                end
                REQ_START: begin
                    push(ACT_START, '0, '0, '0, 1'b0, 1'b0);
                    log_open = 1;
                    push(ACT_OPEN, '0, '0, '0, 1'b0, 1'b0);
                    stopped = 0;
                    push(ACT_STATUS, '0, '0, '0, 1'b1, 1'b0);
                end
                REQ_STOP: begin
                    push(ACT_STOP, '0, '0, '0, 1'b0, 1'b0);
                    close_log();
                    stopped = 1;
                    push(ACT_STATUS, '0, '0, '0, 1'b1, 1'b0);
                end
                REQ_CONNECT: begin
                    if (link && start_on_connect && capable) begin
                        armed_state = armed;
                        stopped     = 0;
                    end
                end
                default: begin
                end
            endcase
            // final result of this request carries the last flag
            if (pending_results.size() > queued_at_entry) begin
                r      = pending_results.pop_back();
                r.last = 1'b1;
                pending_results.push_back(r);
            end
        endfunction

        function void check_result(logic [2:0] act, logic [31:0] blk, logic [39:0] off,
                                   logic [31:0] mask, logic ok, logic untr, logic last);
            log_result_t e;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"unexpected result: act %0d blk %h off %h mask %h ",
                              "ok %b untr %b last %b"},
                             act, blk, off, mask, ok, untr, last);
                return;
            end
            e = pending_results.pop_front();
            if (act !== e.act || blk !== e.blk || off !== e.off || mask !== e.mask ||
                ok !== e.ok || untr !== e.untr || last !== e.last) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("result mismatch at %0t", $realtime);
                    $display("  expected: act %0d blk %h off %h mask %h ok %b untr %b last %b",
                             e.act, e.blk, e.off, e.mask, e.ok, e.untr, e.last);
                    $display("  actual:   act %0d blk %h off %h mask %h ok %b untr %b last %b",
                             act, blk, off, mask, ok, untr, last);
                end
            end
        endfunction
    endclass

    // -----------------------------------------------------------------------
    // clock, reset and block
    // -----------------------------------------------------------------------
    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [39:0]  s_tdata = '0;
    logic [2:0]   s_tuser = REQ_DATA;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [111:0] m_tdata;
    logic [2:0]   m_tuser;
    logic         m_tlast;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic         cfg_data = 1'b0;

    // idle-free stretches on either side, redrawn now and then
    bit tx_quiet = 0;
    bit rx_quiet = 0;

    int cycle_count = 0;

    log_ack_scoreboard sb = new();

    always #5 aclk = ~aclk;

    log_block_ack_nack_receiver_core uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // run limit
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // every result transfer is checked against the oldest expectation;
    // values read here are the ones from before this edge
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tuser, m_tdata[31:0], m_tdata[71:32], m_tdata[103:72],
                            m_tdata[104], m_tdata[105], m_tlast);
    end

    // result side: random stall before each transfer
    initial begin : result_sink
        int stall;
        forever begin
            @(negedge aclk);
            stall = rx_quiet ? 0 : $urandom_range(0, 6);
            if (stall > 0) begin
                m_tready = 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready = 1'b1;
            @(posedge aclk);
            while (!(aresetn && m_tvalid)) @(posedge aclk);
        end
    end

    // -----------------------------------------------------------------------
    // request side
    // -----------------------------------------------------------------------

    // one request transfer after a random gap; the scoreboard hears of it
    // at the edge that accepts it
    task automatic send_request(input logic [2:0] req, input logic [31:0] blk,
                                input bit armed, input bit link, input bit capable);
        int gap;
        gap = tx_quiet ? 0 : $urandom_range(0, 6);
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tuser  = req;
        s_tdata  = {5'd0, capable, link, armed, blk};
        s_tvalid = 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_request(req, blk, armed, link, capable);
    endtask

    // sender holds off until every expected result is out, then lets a
    // full nack sweep worth of cycles pass (requests with no result)
    task automatic settle();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (sb.pending_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_TICKS) @(posedge aclk);
    endtask

    task automatic write_start_on_connect(input bit value);
        @(negedge aclk);
        cfg_data  = value;
        cfg_valid = 1'b1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        sb.start_on_connect = value;
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    // random request, weighted so that most traffic is data blocks and
    // nack ticks on a running receiver with an open log
    task automatic random_request();
        logic [2:0]  req;
        logic [31:0] blk;
        bit          armed;
        bit          link;
        bit          capable;
        int          pick;
        armed   = $urandom_range(0, 1);
        link    = ($urandom_range(0, 3) != 0);
        capable = ($urandom_range(0, 3) != 0);
        pick    = $urandom_range(0, 9);
        case (pick)
            0:       blk = '0;
            1:       blk = $urandom;
            2:       blk = $urandom_range(MAP_DEPTH, 4095);
            3:       blk = $urandom_range(0, MAP_DEPTH - 1);
            default: blk = $urandom_range(0, 95);
        endcase
        pick = $urandom_range(0, 99);
        if (sb.stopped && $urandom_range(0, 1)) begin
            // get the receiver going again
            req     = $urandom_range(0, 1) ? REQ_START : REQ_CONNECT;
            link    = 1;
            capable = 1;
        end else if (!sb.stopped && !sb.log_open && $urandom_range(0, 1)) begin
            req = REQ_DATA;
            blk = '0;
        end else if (pick < 55) begin
            req = REQ_DATA;
        end else if (pick < 70) begin
            req = REQ_NACK;
        end else if (pick < 78) begin
            req = REQ_POLL;
        end else if (pick < 82) begin
            req = REQ_START;
        end else if (pick < 85) begin
            req = REQ_STOP;
        end else if (pick < 95) begin
            req = REQ_CONNECT;
        end else begin
            req = $urandom_range(0, 1) ? REQ_SPARE_6 : REQ_SPARE_7;
        end
        send_request(req, blk, armed, link, capable);
    endtask

    // -----------------------------------------------------------------------
    // test sequence
    // -----------------------------------------------------------------------
    initial begin : main_seq
        // reset held low, released at a falling edge
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        write_start_on_connect(1'b1);

        // directed: stopped receiver, connect variants, log open by block
        // zero, untracked blocks and the largest offset, arm rotation, start/stop,
        // full nack sweep, ignored request codes
        send_request(REQ_DATA,    32'd7,          1'b0, 1'b0, 1'b0);  // stopped: stop
        send_request(REQ_NACK,    32'd0,          1'b0, 1'b0, 1'b0);  // stopped: none
        send_request(REQ_POLL,    32'd0,          1'b1, 1'b0, 1'b0);  // stopped: none
        send_request(REQ_CONNECT, 32'd0,          1'b0, 1'b0, 1'b1);  // link down
        send_request(REQ_CONNECT, 32'd0,          1'b0, 1'b1, 1'b0);  // not capable
        send_request(REQ_CONNECT, 32'd0,          1'b0, 1'b1, 1'b1);  // running
        send_request(REQ_DATA,    32'd5,          1'b0, 1'b0, 1'b0);  // log closed: none
        send_request(REQ_DATA,    32'd0,          1'b0, 1'b0, 1'b0);  // open, write, ack
        send_request(REQ_DATA,    32'd1023,       1'b0, 1'b0, 1'b0);  // top tracked block
        send_request(REQ_DATA,    32'd1024,       1'b0, 1'b0, 1'b0);  // untracked
        send_request(REQ_DATA,    32'hFFFF_FFFF,  1'b1, 1'b1, 1'b1);  // largest block number
        send_request(REQ_DATA,    32'd40,         1'b0, 1'b0, 1'b0);
        send_request(REQ_NACK,    32'd0,          1'b0, 1'b0, 1'b0);
        send_request(REQ_POLL,    32'd0,          1'b0, 1'b0, 1'b0);  // no change
        send_request(REQ_POLL,    32'd0,          1'b1, 1'b0, 1'b0);  // arm: open, start
        send_request(REQ_POLL,    32'd0,          1'b0, 1'b0, 1'b0);  // disarm: stops, close
        send_request(REQ_NACK,    32'd0,          1'b0, 1'b0, 1'b0);  // map empty
        send_request(REQ_DATA,    32'd3,          1'b0, 1'b0, 1'b0);  // log closed: none
        send_request(REQ_STOP,    32'd0,          1'b0, 1'b0, 1'b0);
        send_request(REQ_START,   32'd0,          1'b0, 1'b0, 1'b0);
        send_request(REQ_DATA,    32'd0,          1'b0, 1'b0, 1'b0);
        send_request(REQ_DATA,    32'd1023,       1'b0, 1'b0, 1'b0);
        send_request(REQ_NACK,    32'd0,          1'b0, 1'b0, 1'b0);  // all 32 windows
        send_request(REQ_SPARE_6, 32'd0,          1'b0, 1'b0, 1'b0);
        send_request(REQ_SPARE_7, 32'd0,          1'b0, 1'b0, 1'b0);

        // random phases, each under another start-on-connect setting
        for (int phase = 0; phase < PHASES; phase++) begin
            settle();
            write_start_on_connect(phase[0]);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n % 15 == 0) begin
                    tx_quiet = ($urandom_range(0, 3) == 0);
                    rx_quiet = ($urandom_range(0, 3) == 0);
                end
                random_request();
            end
        end

        settle();
        if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
